/* hw/rtl/adc_lz_decompressor_unit_defines.svh */
// Assertion macros used by the checker file of the ADC decoder.
`ifndef ADC_LZ_DECOMPRESSOR_UNIT_DEFINES_SVH
`define ADC_LZ_DECOMPRESSOR_UNIT_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define ADCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("adcd check failed");

// Check a consequent in the cycle after its antecedent.
`define ADCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("adcd check failed");

`endif

/* hw/rtl/adcd_pkg.sv */
package adcd_pkg;

  // History window geometry
  localparam int WINDOW_BYTES = 65536;
  localparam int WIN_AW       = 16;

  // Header byte fields
  localparam logic [7:0] MASK_PLAIN    = 8'h80;
  localparam logic [7:0] MASK_LONG     = 8'h40;
  localparam logic [7:0] MASK_LIT_LEN  = 8'h7F;
  localparam logic [7:0] MASK_COPY_LEN = 8'h3F;
  localparam logic [7:0] MASK_DIST_HI  = 8'h03;

  // Configuration
  localparam logic [23:0] CAP_RESET   = 24'hFFFFFF;
  localparam logic        REG_IDX_CAP = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARSE,
    ST_DIST,
    ST_COPY,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_LITERAL  = 2'd1,
    PH_DIST_LO  = 2'd2,
    PH_DIST_HI  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    STOP_NONE     = 2'd0,
    STOP_CAPACITY = 2'd1,
    STOP_DISTANCE = 2'd2
  } stop_t;

  // Sequencer to copy engine
  typedef struct packed {
    logic              start;
    logic [WIN_AW-1:0] rp;
    logic [6:0]        len;
  } copy_req_t;

  // Copy engine to sequencer
  typedef struct packed {
    logic       take;
    logic       emit;
    logic       fin;
    logic [7:0] wr_data;
  } copy_stat_t;

endpackage

/* hw/rtl/adcd_ram.sv */
module adcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/adcd_copy.sv */
module adcd_copy import adcd_pkg::*; #(
  parameter int BYTES_PER_RESULT = 4,
  localparam int PW = 8 * BYTES_PER_RESULT,
  localparam int CW = $clog2(BYTES_PER_RESULT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  copy_req_t         req,
  input  logic              out_free,
  input  logic [WIN_AW-1:0] wr_ptr,
  input  logic [7:0]        rd_data,
  output logic              rd_en,
  output logic [WIN_AW-1:0] rd_addr,
  output copy_stat_t        stat,
  output logic [PW-1:0]     word,
  output logic [CW-1:0]     word_cnt
);

  logic [6:0]        iss_left;
  logic [6:0]        con_left;
  logic              rd_pend;
  logic [WIN_AW-1:0] rp;
  logic              hit;
  logic [7:0]        fwd;
  logic [PW-1:0]     pk;
  logic [CW-1:0]     pk_cnt;

  logic [7:0]        cur_data;
  logic [CW-1:0]     pk_cnt_inc;
  logic              full;
  logic              fin;
  logic              emit;
  logic              take;
  logic              issue;

  // Pick the returned byte, forwarding a write that raced the read
  assign cur_data   = hit ? fwd : rd_data;
  assign pk_cnt_inc = pk_cnt + CW'(1);
  assign full       = (pk_cnt_inc == CW'(BYTES_PER_RESULT));
  assign fin        = (con_left == 7'd1);
  assign emit       = full || fin;
  assign take       = rd_pend && (!emit || out_free);
  assign issue      = (iss_left != 7'd0) && (!rd_pend || take);

  assign rd_en    = issue;
  assign rd_addr  = rp;
  assign word     = pk | (PW'(cur_data) << {pk_cnt, 3'b000});
  assign word_cnt = pk_cnt_inc;

  assign stat.take    = take;
  assign stat.emit    = emit;
  assign stat.fin     = fin;
  assign stat.wr_data = cur_data;

  // Counters and pending read
  always_ff @(posedge clk) begin
    if (rst) begin
      iss_left <= '0;
      con_left <= '0;
      rd_pend  <= 1'b0;
      pk_cnt   <= '0;
    end else if (req.start) begin
      iss_left <= req.len;
      con_left <= req.len;
      rd_pend  <= 1'b0;
      pk_cnt   <= '0;
    end else begin
      if (issue) begin
        iss_left <= iss_left - 7'd1;
      end
      rd_pend <= issue || (rd_pend && !take);
      if (take) begin
        con_left <= con_left - 7'd1;
        pk_cnt   <= emit ? '0 : pk_cnt_inc;
      end
    end
  end

  // Read pointer, forward path and pack register
  always_ff @(posedge clk) begin
    if (req.start) begin
      rp <= req.rp;
      pk <= '0;
    end else begin
      if (issue) begin
        rp  <= rp + WIN_AW'(1);
        hit <= take && (rp == wr_ptr);
        fwd <= cur_data;
      end
      if (take) begin
        pk <= emit ? '0 : word;
      end
    end
  end

endmodule

/* hw/rtl/adc_lz_decompressor_unit.sv */
// Channel   | Signals                                      | Moves
// ----------+----------------------------------------------+---------------------------
// bytes in  | byte_valid, byte_ready, in_byte, last        | one compressed byte
// results   | res_valid, res_ready, out_data, out_count,   | up to four decoded bytes,
//           | token_end, done_res, total_length, status    | or the end-of-buffer summary
// config    | psel, penable, pwrite, paddr, pwdata, prdata | out_capacity at address 0
//
// A header or literal byte passes the idle, parse and finish states; a copy token's final
// byte also passes the distance check and the copy, paced by the single read port of the
// history RAM (one byte a cycle unless stalled); a last byte's summary loads in ST_FINISH.
// Reset (synchronous) clears parse state and counts and sets full capacity; history is kept.
// A stalled result holds literal bytes, the summary and the next copy word until transferred.
module adc_lz_decompressor_unit import adcd_pkg::*; #(
  parameter int BYTES_PER_RESULT = 4
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // compressed bytes
  input  logic        byte_valid,
  output logic        byte_ready,
  input  logic [7:0]  in_byte,
  input  logic        last,
  // results
  output logic        res_valid,
  input  logic        res_ready,
  output logic [31:0] out_data,
  output logic [2:0]  out_count,
  output logic        token_end,
  output logic        done_res,
  output logic [23:0] total_length,
  output logic [1:0]  status
);

  localparam int PW = 8 * BYTES_PER_RESULT;
  localparam int CW = $clog2(BYTES_PER_RESULT + 1);

  state_t      state, state_next;
  phase_t      phase, phase_next;
  stop_t       stop, stop_next;
  logic [7:0]  lit_rem, lit_rem_next;
  logic [6:0]  copy_len, copy_len_next;
  logic [7:0]  dist_hi, dist_hi_next;
  logic [23:0] bw, bw_next;
  logic [23:0] cap;
  logic [7:0]  cur_byte;
  logic        cur_last;

  logic        out_free;
  logic        load;
  logic [31:0] ld_data;
  logic [2:0]  ld_count;
  logic        ld_end;
  logic        ld_done;
  logic [1:0]  ld_status;
  logic        lit_wr;

  logic [23:0] cmp_a, cmp_b, cmp_c;
  logic        cmp_gt;
  logic [7:0]  lit_len;
  logic [23:0] bw_inc;

  copy_req_t         creq;
  copy_stat_t        cstat;
  logic [PW-1:0]     cword;
  logic [CW-1:0]     cword_cnt;
  logic [PW+31:0]    cword_ext;
  logic [CW+2:0]     ccnt_ext;
  logic              rd_en;
  logic [WIN_AW-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              wr_en;
  logic [7:0]        wr_data;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_CAP) ? {8'd0, cap} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_IDX_CAP)) begin
      cap <= pwdata[23:0];
    end
  end

  // Shared adder and comparator: a + b > c
  assign lit_len = (cur_byte & MASK_LIT_LEN) + 8'd1;
  assign bw_inc  = bw + 24'd1;

  always_comb begin
    if (state == ST_DIST) begin
      cmp_a = {8'd0, dist_hi, cur_byte};
      cmp_b = 24'd1;
      cmp_c = bw;
    end else begin
      cmp_a = bw;
      cmp_b = (phase == PH_HEADER) ? {16'd0, lit_len} : {17'd0, copy_len};
      cmp_c = cap;
    end
  end

  assign cmp_gt = ({1'b0, cmp_a} + {1'b0, cmp_b}) > {1'b0, cmp_c};

  // Copy word narrowed to the result fields
  assign cword_ext = {32'd0, cword};
  assign ccnt_ext  = {3'd0, cword_cnt};

  assign out_free = !res_valid || res_ready;

  // Sequencer: next state and datapath controls
  always_comb begin
    state_next    = state;
    phase_next    = phase;
    stop_next     = stop;
    lit_rem_next  = lit_rem;
    copy_len_next = copy_len;
    dist_hi_next  = dist_hi;
    bw_next       = bw;
    byte_ready    = 1'b0;
    load          = 1'b0;
    ld_data       = 32'd0;
    ld_count      = 3'd0;
    ld_end        = 1'b0;
    ld_done       = 1'b0;
    ld_status     = STOP_NONE;
    lit_wr        = 1'b0;
    creq.start    = 1'b0;
    creq.rp       = bw[WIN_AW-1:0] + ~{dist_hi, cur_byte};
    creq.len      = copy_len;
    case (state)
      ST_IDLE: begin
        byte_ready = 1'b1;
        if (byte_valid) begin
          state_next = ST_PARSE;
        end
      end
      ST_PARSE: begin
        if (stop != STOP_NONE) begin
          state_next = ST_FINISH;
        end else begin
          case (phase)
            PH_HEADER: begin
              state_next = ST_FINISH;
              if ((cur_byte & MASK_PLAIN) != 8'd0) begin
                if (cmp_gt) begin
                  stop_next = STOP_CAPACITY;
                end else begin
                  lit_rem_next = lit_len;
                  phase_next   = PH_LITERAL;
                end
              end else if ((cur_byte & MASK_LONG) != 8'd0) begin
                copy_len_next = {1'b0, cur_byte[5:0]} + 7'd4;
                phase_next    = PH_DIST_HI;
              end else begin
                copy_len_next = {3'd0, cur_byte[5:2]} + 7'd3;
                dist_hi_next  = cur_byte & MASK_DIST_HI;
                phase_next    = PH_DIST_LO;
              end
            end
            PH_LITERAL: begin
              // wait for room in the result register
              if (out_free) begin
                load         = 1'b1;
                ld_data      = {24'd0, cur_byte};
                ld_count     = 3'd1;
                ld_end       = !cur_last;
                lit_wr       = 1'b1;
                bw_next      = bw_inc;
                lit_rem_next = lit_rem - 8'd1;
                if (lit_rem == 8'd1) begin
                  phase_next = PH_HEADER;
                end
                state_next = ST_FINISH;
              end
            end
            PH_DIST_HI: begin
              dist_hi_next = cur_byte;
              phase_next   = PH_DIST_LO;
              state_next   = ST_FINISH;
            end
            PH_DIST_LO: begin
              phase_next = PH_HEADER;
              if (cmp_gt) begin
                stop_next  = STOP_CAPACITY;
                state_next = ST_FINISH;
              end else begin
                state_next = ST_DIST;
              end
            end
            default: begin
              state_next = ST_FINISH;
            end
          endcase
        end
      end
      ST_DIST: begin
        // distance reaching before the first byte of this buffer
        if (cmp_gt) begin
          stop_next  = STOP_DISTANCE;
          state_next = ST_FINISH;
        end else begin
          creq.start = 1'b1;
          state_next = ST_COPY;
        end
      end
      ST_COPY: begin
        if (cstat.take) begin
          bw_next = bw_inc;
          if (cstat.emit) begin
            load     = 1'b1;
            ld_data  = cword_ext[31:0];
            ld_count = ccnt_ext[2:0];
            ld_end   = cstat.fin && !cur_last;
          end
          if (cstat.fin) begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        if (!cur_last) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          // summary, then clear for the next buffer
          load          = 1'b1;
          ld_end        = 1'b1;
          ld_done       = 1'b1;
          ld_status     = stop;
          phase_next    = PH_HEADER;
          stop_next     = STOP_NONE;
          lit_rem_next  = 8'd0;
          copy_len_next = 7'd0;
          dist_hi_next  = 8'd0;
          bw_next       = 24'd0;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer and buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      phase    <= PH_HEADER;
      stop     <= STOP_NONE;
      lit_rem  <= 8'd0;
      copy_len <= 7'd0;
      dist_hi  <= 8'd0;
      bw       <= 24'd0;
    end else begin
      state    <= state_next;
      phase    <= phase_next;
      stop     <= stop_next;
      lit_rem  <= lit_rem_next;
      copy_len <= copy_len_next;
      dist_hi  <= dist_hi_next;
      bw       <= bw_next;
    end
  end

  // Hold the accepted byte
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      cur_byte <= in_byte;
      cur_last <= last;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data     <= ld_data;
      out_count    <= ld_count;
      token_end    <= ld_end;
      done_res     <= ld_done;
      total_length <= ld_done ? bw : bw_inc;
      status       <= ld_status;
    end
  end

  // History window
  assign wr_en   = lit_wr || cstat.take;
  assign wr_data = lit_wr ? cur_byte : cstat.wr_data;

  adcd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_hist (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (bw[WIN_AW-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  adcd_copy #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_copy (
    .clk      (clk),
    .rst      (rst),
    .req      (creq),
    .out_free (out_free),
    .wr_ptr   (bw[WIN_AW-1:0]),
    .rd_data  (rd_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .stat     (cstat),
    .word     (cword),
    .word_cnt (cword_cnt)
  );

endmodule

/* hw/rtl/adcd_checker.sv */
`include "adc_lz_decompressor_unit_defines.svh"

module adcd_checker import adcd_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [31:0] out_data,
  input logic [2:0]  out_count,
  input logic        token_end,
  input logic        done_res,
  input logic [23:0] total_length,
  input logic [1:0]  status
);

  // Nothing is offered in the first cycle after reset
  `ADCD_ASSERT_SAME(a_quiet_after_reset, $past(rst), !res_valid)

  // A stalled result holds its payload
  `ADCD_ASSERT_NEXT(a_stall_hold, res_valid && !res_ready,
    res_valid && $stable(out_data) && $stable(total_length) && $stable(done_res))

  // A summary carries no bytes and closes the input byte
  `ADCD_ASSERT_SAME(a_summary_form, res_valid && done_res,
    out_count == 3'd0 && out_data == 32'd0 && token_end)

  // Data results report no stop code and at most four bytes
  `ADCD_ASSERT_SAME(a_data_status, res_valid && !done_res,
    status == STOP_NONE && out_count <= 3'd4)

endmodule

bind adc_lz_decompressor_unit adcd_checker u_chk (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import adcd_pkg::*;

  localparam int BYTES_PER_RESULT = 4;
  localparam int RAND_ITEMS       = 230;
  localparam int LAT_CYCLES       = 100;
  localparam int HOLD_CYCLES      = 300;
  localparam int STALL_LIMIT      = 5000;
  // out_capacity is register 0, one 32-bit word per register
  localparam logic [2:0] CAP_ADDR = {REG_IDX_CAP, 2'b00};

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  count;
    logic        te;
    logic        done;
    logic [23:0] total;
    stop_t       st;
  } dec_result_t;

  typedef enum logic {ROW_BYTE, ROW_CAP} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [23:0] value;
    logic        lst;
    logic        typed;
    dec_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        byte_valid = 1'b0;
  logic        byte_ready;
  logic [7:0]  in_byte = '0;
  logic        last = 1'b0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  logic [31:0] out_data;
  logic [2:0]  out_count;
  logic        token_end;
  logic        done_res;
  logic [23:0] total_length;
  logic [1:0]  status;

  // Decoder shadow state
  logic [7:0]  hist [0:WINDOW_BYTES-1];
  phase_t      pv_phase = PH_HEADER;
  logic [7:0]  pv_lit_left = '0;
  logic [6:0]  pv_len = '0;
  logic [7:0]  pv_dist_hi = '0;
  logic [23:0] pv_written = '0;
  stop_t       pv_stop = STOP_NONE;
  logic [23:0] pv_cap = CAP_RESET;

  dec_result_t step_q [$];
  dec_result_t decoded_q [$];
  dir_row_t    dir_tab [$];
  logic [7:0]  tok_bytes [$];
  int          planned_len;
  int          items;
  int          fail_cnt;
  int          stall_cycles;
  int          hold_asks;
  bit          quiet;

  adc_lz_decompressor_unit #(.BYTES_PER_RESULT(BYTES_PER_RESULT)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .byte_valid(byte_valid), .byte_ready(byte_ready), .in_byte(in_byte), .last(last),
    .res_valid(res_valid), .res_ready(res_ready), .out_data(out_data),
    .out_count(out_count), .token_end(token_end), .done_res(done_res),
    .total_length(total_length), .status(status)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_cnt < 100) begin
      $display("%0t ns: %s mismatch, got %0h, want %0h", $time, what, got, want);
    end
    fail_cnt++;
  endtask

  function automatic dec_result_t data_result(input logic [31:0] data, input int cnt);
    dec_result_t r;
    r.data  = data;
    r.count = 3'(cnt);
    r.te    = 1'b0;
    r.done  = 1'b0;
    r.total = pv_written;
    r.st    = STOP_NONE;
    return r;
  endfunction

  // Decode one compressed byte into step_q
  task automatic decode_byte(input logic [7:0] b, input logic lst);
    dec_result_t r;
    int          len;
    int          off;
    int          cnt;
    int          i;
    logic [7:0]  v;
    logic [31:0] acc;
    step_q.delete();
    if (pv_stop == STOP_NONE) begin
      case (pv_phase)
        PH_HEADER: begin
          if ((b & MASK_PLAIN) != 0) begin
            len = int'(b & MASK_LIT_LEN) + 1;
            if (int'(pv_written) + len > int'(pv_cap)) begin
              pv_stop = STOP_CAPACITY;
            end else begin
              pv_lit_left = 8'(len);
              pv_phase    = PH_LITERAL;
            end
          end else if ((b & MASK_LONG) != 0) begin
            pv_len   = 7'((b & MASK_COPY_LEN) + 8'd4);
            pv_phase = PH_DIST_HI;
          end else begin
            pv_len     = 7'(((b & MASK_COPY_LEN) >> 2) + 8'd3);
            pv_dist_hi = b & MASK_DIST_HI;
            pv_phase   = PH_DIST_LO;
          end
        end
        PH_LITERAL: begin
          hist[pv_written[15:0]] = b;
          pv_written++;
          step_q.push_back(data_result({24'h0, b}, 1));
          pv_lit_left--;
          if (pv_lit_left == 0) pv_phase = PH_HEADER;
        end
        PH_DIST_HI: begin
          pv_dist_hi = b;
          pv_phase   = PH_DIST_LO;
        end
        default: begin
          off      = int'({pv_dist_hi, b});
          len      = int'(pv_len);
          pv_phase = PH_HEADER;
          if (int'(pv_written) + len > int'(pv_cap)) begin
            pv_stop = STOP_CAPACITY;
          end else if (off + 1 > int'(pv_written)) begin
            pv_stop = STOP_DISTANCE;
          end else begin
            // copy byte by byte so overlapping copies repeat
            acc = '0;
            cnt = 0;
            for (i = 0; i < len; i++) begin
              v = hist[16'(pv_written - 24'(off) - 24'd1)];
              hist[pv_written[15:0]] = v;
              pv_written++;
              acc = acc | (32'(v) << (8 * cnt));
              cnt++;
              if (cnt == BYTES_PER_RESULT || i + 1 == len) begin
                step_q.push_back(data_result(acc, cnt));
                acc = '0;
                cnt = 0;
              end
            end
          end
        end
      endcase
    end
    // close the buffer with a summary and clear parse state
    if (lst) begin
      r       = data_result('0, 0);
      r.done  = 1'b1;
      r.st    = pv_stop;
      step_q.push_back(r);
      pv_phase    = PH_HEADER;
      pv_lit_left = '0;
      pv_len      = '0;
      pv_dist_hi  = '0;
      pv_written  = '0;
      pv_stop     = STOP_NONE;
    end
    if (step_q.size() > 0) begin
      r    = step_q.pop_back();
      r.te = 1'b1;
      step_q.push_back(r);
    end
  endtask

  // Offer one byte, hold it until the transfer, then queue what it decodes to
  task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                           input dec_result_t typed_res);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    in_byte    <= b;
    last       <= lst;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    decode_byte(b, lst);
    if (typed) begin
      decoded_q.push_back(typed_res);
    end else begin
      foreach (step_q[k]) decoded_q.push_back(step_q[k]);
    end
    items++;
  endtask

  // Drain all results and let the block settle
  task automatic wait_idle();
    byte_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
  endtask

  // Write out_capacity, then read it back
  task automatic write_capacity(input logic [23:0] v);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CAP_ADDR;
    pwdata  <= {8'h0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    pv_cap  = v;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[23:0] !== v) report_mismatch("out_capacity readback", prdata, {8'h0, v});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Build one token into tok_bytes, mostly well formed
  task automatic build_token();
    int kind;
    int n;
    int d;
    int top;
    kind = $urandom_range(0, 99);
    tok_bytes.delete();
    if (planned_len == 0 || kind < 35) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
      tok_bytes.push_back(MASK_PLAIN | 8'(n - 1));
      repeat (n) tok_bytes.push_back(8'($urandom_range(0, 255)));
      planned_len += n;
    end else if (kind < 65) begin
      n   = $urandom_range(3, 18);
      top = (planned_len - 1 < 1023) ? planned_len - 1 : 1023;
      d   = $urandom_range(0, top);
      tok_bytes.push_back(8'(((n - 3) << 2) | (d >> 8)));
      tok_bytes.push_back(8'(d));
      planned_len += n;
    end else if (kind < 92) begin
      n   = $urandom_range(4, 67);
      top = (planned_len - 1 < 65535) ? planned_len - 1 : 65535;
      d   = $urandom_range(0, top);
      tok_bytes.push_back(MASK_LONG | 8'(n - 4));
      tok_bytes.push_back(8'(d >> 8));
      tok_bytes.push_back(8'(d));
      planned_len += n;
    end else if (kind < 97) begin
      // reach back past the start of the buffer
      d = $urandom_range(planned_len, 65535);
      tok_bytes.push_back(MASK_LONG | 8'($urandom_range(0, 63)));
      tok_bytes.push_back(8'(d >> 8));
      tok_bytes.push_back(8'(d));
    end else begin
      repeat ($urandom_range(1, 3)) tok_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // Send one buffer of random tokens, sometimes cut short at the end
  task automatic send_buffer();
    int n_tok;
    int t;
    n_tok       = $urandom_range(1, 8);
    planned_len = 0;
    for (t = 0; t < n_tok; t++) begin
      build_token();
      if (t == n_tok - 1 && tok_bytes.size() > 1 && $urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, tok_bytes.size() - 1)) void'(tok_bytes.pop_back());
      end
      foreach (tok_bytes[k]) begin
        send_byte(tok_bytes[k], (t == n_tok - 1) && (k == tok_bytes.size() - 1),
                  1'b0, '0);
      end
    end
  endtask

  function automatic dir_row_t byte_row(input logic [7:0] b, input logic lst);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_BYTE;
    r.value = {16'h0, b};
    r.lst   = lst;
    return r;
  endfunction

  function automatic dir_row_t lit_row(input logic [7:0] b, input logic [23:0] total);
    dir_row_t r;
    r             = byte_row(b, 1'b0);
    r.typed       = 1'b1;
    r.res.data    = {24'h0, b};
    r.res.count   = 3'd1;
    r.res.te      = 1'b1;
    r.res.total   = total;
    r.res.st      = STOP_NONE;
    return r;
  endfunction

  function automatic dir_row_t sum_row(input logic [7:0] b, input logic [23:0] total,
                                       input stop_t st);
    dir_row_t r;
    r           = byte_row(b, 1'b1);
    r.typed     = 1'b1;
    r.res.te    = 1'b1;
    r.res.done  = 1'b1;
    r.res.total = total;
    r.res.st    = st;
    return r;
  endfunction

  function automatic dir_row_t cap_row(input logic [23:0] v);
    dir_row_t r;
    r       = '0;
    r.kind  = ROW_CAP;
    r.value = v;
    return r;
  endfunction

  // Drive the receiver: one long hold-off on request, else short random stalls
  initial begin : rx_drive
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        res_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
      res_ready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    dec_result_t e;
    if (!rst && res_valid && res_ready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected result, out_data", out_data, '0);
      end else begin
        e = decoded_q.pop_front();
        if (out_data !== e.data) report_mismatch("out_data", out_data, e.data);
        if (out_count !== e.count) report_mismatch("out_count", 32'(out_count), 32'(e.count));
        if (token_end !== e.te) report_mismatch("token_end", 32'(token_end), 32'(e.te));
        if (done_res !== e.done) report_mismatch("done_res", 32'(done_res), 32'(e.done));
        if (total_length !== e.total) begin
          report_mismatch("total_length", 32'(total_length), 32'(e.total));
        end
        if (status !== 2'(e.st)) report_mismatch("status", 32'(status), 32'(e.st));
      end
    end
  end

  // End the run when nothing transfers for too long
  always @(posedge clk) begin
    if ((byte_valid && byte_ready) || (res_valid && res_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : run
    logic [23:0] cap;
    int          target;
    int          ph;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // plain token with extreme bytes, zero-distance overlap, short and long copies,
    // then a distance reaching before the start; stopped bytes are ignored
    dir_tab.push_back(byte_row(8'h81, 1'b0));
    dir_tab.push_back(lit_row(8'h00, 24'd1));
    dir_tab.push_back(lit_row(8'hFF, 24'd2));
    dir_tab.push_back(byte_row(8'h3C, 1'b0));
    dir_tab.push_back(byte_row(8'h00, 1'b0));
    dir_tab.push_back(byte_row(8'h40, 1'b0));
    dir_tab.push_back(byte_row(8'h00, 1'b0));
    dir_tab.push_back(byte_row(8'h13, 1'b0));
    dir_tab.push_back(byte_row(8'h7F, 1'b0));
    dir_tab.push_back(byte_row(8'h00, 1'b0));
    dir_tab.push_back(byte_row(8'h03, 1'b0));
    dir_tab.push_back(byte_row(8'h03, 1'b0));
    dir_tab.push_back(byte_row(8'hFF, 1'b0));
    dir_tab.push_back(sum_row(8'h12, 24'd91, STOP_DISTANCE));
    // partial plain token: emitted literals stay counted
    dir_tab.push_back(byte_row(8'h85, 1'b0));
    dir_tab.push_back(lit_row(8'h11, 24'd1));
    dir_tab.push_back(byte_row(8'h22, 1'b1));
    // zero capacity stops a plain token at its header; partial copy header dropped
    dir_tab.push_back(cap_row(24'd0));
    dir_tab.push_back(byte_row(8'h80, 1'b0));
    dir_tab.push_back(sum_row(8'h00, 24'd0, STOP_CAPACITY));
    dir_tab.push_back(sum_row(8'h40, 24'd0, STOP_NONE));
    // fill capacity exactly, then a copy passing it
    dir_tab.push_back(cap_row(24'd4));
    dir_tab.push_back(byte_row(8'h83, 1'b0));
    dir_tab.push_back(lit_row(8'h01, 24'd1));
    dir_tab.push_back(lit_row(8'h02, 24'd2));
    dir_tab.push_back(lit_row(8'h04, 24'd3));
    dir_tab.push_back(lit_row(8'h08, 24'd4));
    dir_tab.push_back(byte_row(8'h00, 1'b0));
    dir_tab.push_back(sum_row(8'h00, 24'd4, STOP_CAPACITY));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CAP) begin
        write_capacity(dir_tab[i].value);
      end else begin
        send_byte(dir_tab[i].value[7:0], dir_tab[i].lst, dir_tab[i].typed, dir_tab[i].res);
      end
    end

    // random buffers under several capacity settings
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: cap = CAP_RESET;
        1: cap = 24'($urandom_range(16, 300));
        2: cap = 24'($urandom_range(0, 24'hFFFFFF));
        default: cap = CAP_RESET;
      endcase
      write_capacity(cap);
      if (ph == 1) hold_asks++;
      if (ph == 3) quiet = 1'b1;
      target = items + RAND_ITEMS / 4;
      while (items < target) send_buffer();
    end

    // drain and finish
    byte_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && decoded_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
